// File: design/kcact_pkg.sv
// ----------------------------------------------------------------------------
// kcact_pkg
// Shared types and constants for the keyed cardinality accumulate table.
// ----------------------------------------------------------------------------
`default_nettype none

package kcact_pkg;

  localparam int STEP_W = 16;
  localparam int KEY_W  = STEP_W + 2;
  localparam int CARD_W = 48;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [CARD_W-1:0] CARD_MAX = {CARD_W{1'b1}};

  localparam logic OP_PRODUCE = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_PRODUCED  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_CONSUMED  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [CARD_W-1:0] count;
    logic              len_valid;
    logic [LEN_W-1:0]  len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic compare;
    logic encode;
    logic update;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// File: design/kcact_req_if.sv
// ----------------------------------------------------------------------------
// kcact_req_if
// Request channel: valid/ready handshake with the table operation payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcact_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [kcact_pkg::STEP_W-1:0]  step_number;
  logic                          forward_flag;
  logic                          left_flag;
  logic [kcact_pkg::CARD_W-1:0]  card_in;
  logic                          len_in_valid;
  logic [kcact_pkg::LEN_W-1:0]   len_in;

  modport source (
    output valid, opcode, step_number, forward_flag, left_flag, card_in,
           len_in_valid, len_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, step_number, forward_flag, left_flag, card_in,
           len_in_valid, len_in,
    output ready
  );
endinterface

`default_nettype wire

// File: design/kcact_rsp_if.sv
// ----------------------------------------------------------------------------
// kcact_rsp_if
// Response channel: valid/ready handshake with the operation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcact_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [kcact_pkg::STAT_W-1:0]  status;
  logic [kcact_pkg::CARD_W-1:0]  card_out;
  logic                          len_out_valid;
  logic [kcact_pkg::LEN_W-1:0]   len_out;

  modport source (
    output valid, status, card_out, len_out_valid, len_out,
    input  ready
  );
  modport sink (
    input  valid, status, card_out, len_out_valid, len_out,
    output ready
  );
endinterface

`default_nettype wire

// File: design/keyed_card_accumulate_consume_table.sv
// A request is captured when accepted, then passes the key compare, the slot select
// with entry RAM read, and the update step that loads the output register; a result
// left waiting holds the update step. No request is taken before the update step ends.
// A new request is taken while the previous result still waits to be taken.
// Reset (synchronous) clears the entry valid bits and control at once; no
// clearing pass, entry RAM contents are don't-care until written.
// ----------------------------------------------------------------------------
// keyed_card_accumulate_consume_table
// Associative table keyed by step number and two direction bits; produce
// inserts or accumulates a saturating cardinality, consume reads and frees.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_card_accumulate_consume_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  kcact_req_if.sink    req,
  kcact_rsp_if.source  rsp
);

  kcact_pkg::ctl_cmd_t cmd;

  kcact_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  kcact_dp #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (req.opcode),
    .step_number   (req.step_number),
    .forward_flag  (req.forward_flag),
    .left_flag     (req.left_flag),
    .card_in       (req.card_in),
    .len_in_valid  (req.len_in_valid),
    .len_in        (req.len_in),
    .status        (rsp.status),
    .card_out      (rsp.card_out),
    .len_out_valid (rsp.len_out_valid),
    .len_out       (rsp.len_out)
  );

endmodule

`default_nettype wire

// File: design/kcact_ram.sv
// ----------------------------------------------------------------------------
// kcact_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kcact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/kcact_ctrl.sv
// ----------------------------------------------------------------------------
// kcact_ctrl
// Sequencer: capture, key compare, slot select / entry read, update.
// ----------------------------------------------------------------------------
`default_nettype none

module kcact_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output kcact_pkg::ctl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_UPD
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd.capture = (state == S_IDLE) && req_valid;
    cmd.compare = (state == S_CMP);
    cmd.encode  = (state == S_ENC);
    cmd.update  = (state == S_UPD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_UPD) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_ENC;
        end
        S_ENC: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/kcact_dp.sv
// ----------------------------------------------------------------------------
// kcact_dp
// Datapath: key CAM with valid bits, entry RAM, accumulate and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module kcact_dp #(
  parameter int ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  kcact_pkg::ctl_cmd_t                cmd,
  input  wire logic                          opcode,
  input  wire logic [kcact_pkg::STEP_W-1:0]  step_number,
  input  wire logic                          forward_flag,
  input  wire logic                          left_flag,
  input  wire logic [kcact_pkg::CARD_W-1:0]  card_in,
  input  wire logic                          len_in_valid,
  input  wire logic [kcact_pkg::LEN_W-1:0]   len_in,
  output logic      [kcact_pkg::STAT_W-1:0]  status,
  output logic      [kcact_pkg::CARD_W-1:0]  card_out,
  output logic                               len_out_valid,
  output logic      [kcact_pkg::LEN_W-1:0]   len_out
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // captured request
  logic                          op;
  logic [kcact_pkg::KEY_W-1:0]   key;
  logic [kcact_pkg::CARD_W-1:0]  card;
  logic                          lv;
  logic [kcact_pkg::LEN_W-1:0]   len;

  // table
  logic [ENTRIES-1:0]            used;
  logic [kcact_pkg::KEY_W-1:0]   key_tab [ENTRIES];

  logic [ENTRIES-1:0]            hit_vec;
  logic [ENTRIES-1:0]            free_vec;
  logic [AW-1:0]                 hit_idx;
  logic [AW-1:0]                 free_idx;
  logic [AW-1:0]                 sel_idx;
  logic [AW-1:0]                 slot;
  logic                          hit;
  logic                          full;

  kcact_pkg::entry_t             rd_entry;
  kcact_pkg::entry_t             wr_entry;
  logic                          wr_en;
  logic                          set_used;
  logic                          clr_used;
  logic [kcact_pkg::CARD_W:0]    sum;
  logic [kcact_pkg::STAT_W-1:0]  status_next;
  logic [kcact_pkg::CARD_W-1:0]  card_out_next;
  logic                          len_out_valid_next;
  logic [kcact_pkg::LEN_W-1:0]   len_out_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= opcode;
      key  <= {step_number, forward_flag, left_flag};
      card <= card_in;
      lv   <= len_in_valid;
      len  <= len_in_valid ? len_in : '0;
    end
  end

  // parallel compare, registered
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec[i]  <= used[i] && (key_tab[i] == key);
        free_vec[i] <= !used[i];
      end
    end
  end

  // keys are unique, so the hit vector is one-hot or empty
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | AW'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = AW'(i);
      end
    end
    sel_idx = (|hit_vec) ? hit_idx : free_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.encode) begin
      slot <= sel_idx;
      hit  <= |hit_vec;
      full <= ~|free_vec;
    end
  end

  kcact_ram #(
    .WIDTH (kcact_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (wr_entry),
    .re    (cmd.encode),
    .raddr (sel_idx),
    .rdata (rd_entry)
  );

  assign sum = {1'b0, rd_entry.count} + {1'b0, card};

  always_comb begin
    wr_en              = 1'b0;
    set_used           = 1'b0;
    clr_used           = 1'b0;
    wr_entry.count     = card;
    wr_entry.len_valid = lv;
    wr_entry.len       = len;
    status_next        = kcact_pkg::STATUS_PRODUCED;
    card_out_next      = '0;
    len_out_valid_next = 1'b0;
    len_out_next       = '0;
    if (op == kcact_pkg::OP_PRODUCE) begin
      if (hit) begin
        wr_en          = cmd.update;
        wr_entry.count = sum[kcact_pkg::CARD_W] ? kcact_pkg::CARD_MAX
                                                : sum[kcact_pkg::CARD_W-1:0];
        if (rd_entry.len_valid) begin
          wr_entry.len_valid = 1'b1;
          wr_entry.len       = rd_entry.len;
        end
      end else if (full) begin
        status_next = kcact_pkg::STATUS_FULL;
      end else begin
        wr_en    = cmd.update;
        set_used = cmd.update;
      end
    end else begin
      if (hit) begin
        clr_used           = cmd.update;
        status_next        = kcact_pkg::STATUS_CONSUMED;
        card_out_next      = rd_entry.count;
        len_out_valid_next = rd_entry.len_valid;
        len_out_next       = rd_entry.len_valid ? rd_entry.len : '0;
      end else begin
        status_next = kcact_pkg::STATUS_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (set_used) begin
      used[slot] <= 1'b1;
    end else if (clr_used) begin
      used[slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (set_used) begin
      key_tab[slot] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      status        <= status_next;
      card_out      <= card_out_next;
      len_out_valid <= len_out_valid_next;
      len_out       <= len_out_next;
    end
  end

endmodule

`default_nettype wire

// File: design/kcact_chk.sv
// ----------------------------------------------------------------------------
// kcact_chk
// Port-level checks for the keyed cardinality table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcact_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [kcact_pkg::STAT_W-1:0]  status,
  input wire logic [kcact_pkg::CARD_W-1:0]  card_out
);

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(card_out))
    else $error("response payload changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("second request taken while one is in flight");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_fire && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
    else $error("response appeared too early");

endmodule

bind keyed_card_accumulate_consume_table kcact_chk u_kcact_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .card_out  (rsp.card_out)
);

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed cardinality accumulate / consume table.
// A short table of directed requests covers the key extremes, saturation,
// the length rules, a full table and slot reuse. Random requests follow,
// built mostly from keys that the table holds or a small key pool. A local
// model of the table predicts every response, and random stalls are applied
// on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import kcact_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int RANDOM_REQS   = 1925;
  localparam int POOL_KEYS     = 32;
  localparam int IDLE_LIMIT    = 4000;

  typedef struct packed {
    logic              opcode;
    logic [STEP_W-1:0] step;
    logic              fwd;
    logic              left;
    logic [CARD_W-1:0] card;
    logic              lv;
    logic [LEN_W-1:0]  len;
  } op_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CARD_W-1:0] card;
    logic              has_len;
    logic [LEN_W-1:0]  len;
  } op_res_t;

  typedef struct {
    op_req_t rq;
    bit      typed;
    op_res_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  kcact_req_if req ();
  kcact_rsp_if rsp ();

  keyed_card_accumulate_consume_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // model of the table contents
  bit                slot_used   [TABLE_ENTRIES];
  logic [KEY_W-1:0]  slot_key    [TABLE_ENTRIES];
  logic [CARD_W-1:0] slot_count  [TABLE_ENTRIES];
  logic              slot_has_len[TABLE_ENTRIES];
  logic [LEN_W-1:0]  slot_len    [TABLE_ENTRIES];

  op_res_t          owed_results[$];
  dir_row_t         dir_rows[$];
  logic [KEY_W-1:0] key_pool[POOL_KEYS];
  int               mismatches = 0;
  int               idle_cycles = 0;
  bit               calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic op_res_t apply_table_op(input op_req_t rq);
    op_res_t          res;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [CARD_W:0]  sum;
    int               hit;
    int               free_slot;
    res       = '0;
    key       = {rq.step, rq.fwd, rq.left};
    len       = rq.lv ? rq.len : '0;
    hit       = -1;
    free_slot = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    if (rq.opcode == OP_PRODUCE) begin
      res.status = STATUS_PRODUCED;
      if (hit >= 0) begin
        sum = {1'b0, slot_count[hit]} + {1'b0, rq.card};
        slot_count[hit] = sum[CARD_W] ? CARD_MAX : sum[CARD_W-1:0];
        if (!slot_has_len[hit]) begin
          slot_has_len[hit] = rq.lv;
          slot_len[hit]     = len;
        end
      end else if (free_slot < 0) begin
        res.status = STATUS_FULL;
      end else begin
        slot_used[free_slot]    = 1'b1;
        slot_key[free_slot]     = key;
        slot_count[free_slot]   = rq.card;
        slot_has_len[free_slot] = rq.lv;
        slot_len[free_slot]     = len;
      end
    end else if (hit < 0) begin
      res.status = STATUS_NOT_FOUND;
    end else begin
      res.status      = STATUS_CONSUMED;
      res.card        = slot_count[hit];
      res.has_len     = slot_has_len[hit];
      res.len         = slot_has_len[hit] ? slot_len[hit] : '0;
      slot_used[hit]  = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_held_key(output bit found);
    int held[$];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i]) held.push_back(i);
    end
    found = held.size() != 0;
    if (!found) return '0;
    return slot_key[held[$urandom_range(0, held.size() - 1)]];
  endfunction

  function automatic op_req_t mk_req(input logic op, input logic [KEY_W-1:0] key,
                                     input logic [CARD_W-1:0] card, input logic lv,
                                     input logic [LEN_W-1:0] len);
    // key packs step, forward flag and left flag in field order
    return {op, key, card, lv, len};
  endfunction

  function automatic op_res_t mk_res(input logic [STAT_W-1:0] status,
                                     input logic [CARD_W-1:0] card,
                                     input logic has_len, input logic [LEN_W-1:0] len);
    return {status, card, has_len, len};
  endfunction

  task automatic add_row(input op_req_t rq, input bit typed, input op_res_t want);
    dir_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_req(input op_req_t rq, input bit typed, input op_res_t want);
    int      gap;
    op_res_t pred;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid        <= 1'b1;
    req.opcode       <= rq.opcode;
    req.step_number  <= rq.step;
    req.forward_flag <= rq.fwd;
    req.left_flag    <= rq.left;
    req.card_in      <= rq.card;
    req.len_in_valid <= rq.lv;
    req.len_in       <= rq.len;
    do @(posedge clk); while (!(req.valid && req.ready === 1'b1));
    pred = apply_table_op(rq);
    owed_results.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    op_req_t          rq;
    logic [KEY_W-1:0] key;
    bit               found;
    int               r;
    int               consume_pct;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.opcode       <= OP_PRODUCE;
    req.step_number  <= '0;
    req.forward_flag <= 1'b0;
    req.left_flag    <= 1'b0;
    req.card_in      <= '0;
    req.len_in_valid <= 1'b0;
    req.len_in       <= '0;

    add_row(mk_req(OP_CONSUME, '0, '0, 1'b0, '0), 1'b1,
            mk_res(STATUS_NOT_FOUND, '0, 1'b0, '0));
    add_row(mk_req(OP_PRODUCE, 18'h3FFFF, CARD_MAX, 1'b0, 16'hFFFF), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));
    // saturates, and takes the length since none is held
    add_row(mk_req(OP_PRODUCE, 18'h3FFFF, 48'd1, 1'b1, 16'hFFFF), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));
    add_row(mk_req(OP_CONSUME, 18'h3FFFF, '0, 1'b0, '0), 1'b1,
            mk_res(STATUS_CONSUMED, CARD_MAX, 1'b1, 16'hFFFF));
    add_row(mk_req(OP_PRODUCE, 18'h0, 48'd0, 1'b0, 16'hABCD), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));
    add_row(mk_req(OP_PRODUCE, 18'h0, 48'd5, 1'b0, 16'h1234), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));
    add_row(mk_req(OP_PRODUCE, 18'h1, 48'd3, 1'b1, 16'h0000), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));
    add_row(mk_req(OP_CONSUME, 18'h0, '0, 1'b0, '0), 1'b1,
            mk_res(STATUS_CONSUMED, 48'd5, 1'b0, '0));
    for (int i = 1; i < TABLE_ENTRIES; i++) begin
      add_row(mk_req(OP_PRODUCE, {16'(i * 16'h1111), i[0], i[1]}, CARD_W'(i), i[2],
                     16'(~i)), 1'b0, '0);
    end
    add_row(mk_req(OP_PRODUCE, {16'h8000, 2'b10}, 48'd9, 1'b1, 16'h7777), 1'b1,
            mk_res(STATUS_FULL, '0, 1'b0, '0));
    // held length of zero must not be replaced
    add_row(mk_req(OP_PRODUCE, 18'h1, 48'd7, 1'b1, 16'h0055), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));
    add_row(mk_req(OP_CONSUME, 18'h1, '0, 1'b0, '0), 1'b1,
            mk_res(STATUS_CONSUMED, 48'd10, 1'b1, 16'h0000));
    add_row(mk_req(OP_PRODUCE, {16'h8000, 2'b10}, 48'd9, 1'b1, 16'h7777), 1'b1,
            mk_res(STATUS_PRODUCED, '0, 1'b0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm        = ((n / 120) % 4) == 3;
      consume_pct = ((n / 150) % 2) ? 55 : 20;
      if (n % 400 == 0) begin
        foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom());
      end
      if (n == RANDOM_REQS / 2) wait_drained();

      rq.opcode = ($urandom_range(0, 99) < consume_pct) ? OP_CONSUME : OP_PRODUCE;
      r   = $urandom_range(0, 99);
      key = pick_held_key(found);
      if (!found || r >= ((rq.opcode == OP_CONSUME) ? 70 : 40)) begin
        key = (r < 92) ? key_pool[$urandom_range(0, POOL_KEYS - 1)] : KEY_W'($urandom());
      end
      rq.step = key[KEY_W-1:2];
      rq.fwd  = key[1];
      rq.left = key[0];
      r = $urandom_range(0, 9);
      if (r < 6) rq.card = CARD_W'($urandom_range(0, 4095));
      else if (r < 8) rq.card = CARD_W'({$urandom(), $urandom()});
      else rq.card = CARD_MAX - CARD_W'($urandom_range(0, 3000));
      rq.lv  = 1'($urandom_range(0, 1));
      rq.len = LEN_W'($urandom());
      send_req(rq, 1'b0, '0);
    end
    calm = 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : response_side
    int gap;
    rsp.ready <= 1'b0;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        rsp.ready <= 1'b0;
      end
      @(negedge clk);
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid === 1'b1 && rsp.ready));
    end
  end

  always @(posedge clk) begin : result_check
    op_res_t exp_r;
    if (!rst && rsp.valid === 1'b1 && rsp.ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: response with no request outstanding, status %0d", $time,
                 rsp.status);
        mismatches++;
      end else begin
        exp_r = owed_results.pop_front();
        if (rsp.status !== exp_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.status, rsp.status);
          mismatches++;
        end
        if (rsp.card_out !== exp_r.card) begin
          $display("%0t: card_out expected %0h got %0h", $time, exp_r.card, rsp.card_out);
          mismatches++;
        end
        if (rsp.len_out_valid !== exp_r.has_len) begin
          $display("%0t: len_out_valid expected %0b got %0b", $time, exp_r.has_len,
                   rsp.len_out_valid);
          mismatches++;
        end
        if (rsp.len_out !== exp_r.len) begin
          $display("%0t: len_out expected %0h got %0h", $time, exp_r.len, rsp.len_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready === 1'b1) || (rsp.valid === 1'b1 && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
